/* sv/dbv_pkg.sv */
// ----------------------------------------------------------------------------
// dbv_pkg
// Shared types and constants for the database image length validator.
// ----------------------------------------------------------------------------
package dbv_pkg;

    localparam int HDR_BYTES    = 12;
    localparam int CNT_BYTES    = 4;
    localparam int NUM_SECTIONS = 3;
    localparam int SKIP_W       = 47;
    localparam int ADDR_W       = 5;

    // Register indexes, taken from paddr[4:2]
    localparam logic [2:0] REG_MAGIC    = 3'd0;
    localparam logic [2:0] REG_VERSION  = 3'd1;
    localparam logic [2:0] REG_NODE     = 3'd2;
    localparam logic [2:0] REG_MESSAGE  = 3'd3;
    localparam logic [2:0] REG_WAYPOINT = 3'd4;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] format_version;
        logic [15:0] node_record_size;
        logic [15:0] message_record_size;
        logic [15:0] waypoint_record_size;
    } t_cfg;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_COUNT  = 4'b0010,
        PH_SKIP   = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

endpackage

/* sv/dbv_regs.sv */
// ----------------------------------------------------------------------------
// dbv_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module dbv_regs
    import dbv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_MAGIC:    r_cfg.magic_word           <= pwdata;
                REG_VERSION:  r_cfg.format_version       <= pwdata[15:0];
                REG_NODE:     r_cfg.node_record_size     <= pwdata[15:0];
                REG_MESSAGE:  r_cfg.message_record_size  <= pwdata[15:0];
                REG_WAYPOINT: r_cfg.waypoint_record_size <= pwdata[15:0];
                default: ; // drop writes outside the map
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MAGIC:    prdata = r_cfg.magic_word;
            REG_VERSION:  prdata = {16'h0000, r_cfg.format_version};
            REG_NODE:     prdata = {16'h0000, r_cfg.node_record_size};
            REG_MESSAGE:  prdata = {16'h0000, r_cfg.message_record_size};
            REG_WAYPOINT: prdata = {16'h0000, r_cfg.waypoint_record_size};
            default:      prdata = 32'h0000_0000;
        endcase
    end

endmodule

/* sv/dbv_parser.sv */
// ----------------------------------------------------------------------------
// dbv_parser
// Per-byte image parser: header compare, section counts and record skipping.
// ----------------------------------------------------------------------------
module dbv_parser
    import dbv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  t_cfg       i_cfg,
    output logic       o_complete
);

    t_phase            r_phase, n_phase;
    logic [3:0]        r_pos, n_pos;
    logic [31:0]       r_acc, n_acc;
    logic [SKIP_W-1:0] r_skip, n_skip;
    logic [1:0]        r_sec, n_sec;
    logic              r_failed, n_failed;

    logic              w_end_sec;
    logic [7:0]        w_exp;
    logic [31:0]       w_acc;
    logic [15:0]       w_size;
    logic [SKIP_W-1:0] w_prod;

    always_comb begin
        unique case (r_pos)
            4'd0:    w_exp = i_cfg.magic_word[7:0];
            4'd1:    w_exp = i_cfg.magic_word[15:8];
            4'd2:    w_exp = i_cfg.magic_word[23:16];
            4'd3:    w_exp = i_cfg.magic_word[31:24];
            4'd4:    w_exp = i_cfg.format_version[7:0];
            4'd5:    w_exp = i_cfg.format_version[15:8];
            4'd6:    w_exp = i_cfg.node_record_size[7:0];
            4'd7:    w_exp = i_cfg.node_record_size[15:8];
            4'd8:    w_exp = i_cfg.message_record_size[7:0];
            4'd9:    w_exp = i_cfg.message_record_size[15:8];
            4'd10:   w_exp = i_cfg.waypoint_record_size[7:0];
            4'd11:   w_exp = i_cfg.waypoint_record_size[15:8];
            default: w_exp = 8'h00;
        endcase
    end

    always_comb begin
        unique case (r_sec)
            2'd0:    w_size = i_cfg.node_record_size;
            2'd1:    w_size = i_cfg.message_record_size;
            default: w_size = i_cfg.waypoint_record_size;
        endcase
    end

    // Little-endian count assembly; the multiply only sees a non-negative count
    assign w_acc  = r_acc | (32'(i_byte) << {r_pos[1:0], 3'b000});
    assign w_prod = w_acc[30:0] * w_size;

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_skip    = r_skip;
        n_sec     = r_sec;
        n_failed  = r_failed;
        w_end_sec = 1'b0;
        if (!r_failed) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (i_byte != w_exp) n_failed = 1'b1;
                    n_pos = r_pos + 4'd1;
                    if (r_pos == 4'(HDR_BYTES - 1)) begin
                        n_pos   = 4'd0;
                        n_acc   = 32'd0;
                        n_sec   = 2'd0;
                        n_phase = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    n_acc = w_acc;
                    n_pos = r_pos + 4'd1;
                    if (r_pos == 4'(CNT_BYTES - 1)) begin
                        if (w_acc[31]) begin
                            n_failed = 1'b1;
                        end else begin
                            n_skip = w_prod;
                            // zero product known from the operands
                            if (w_acc == 32'd0 || w_size == 16'd0) w_end_sec = 1'b1;
                            else n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - SKIP_W'(1);
                    if (r_skip[SKIP_W-1:1] == '0) w_end_sec = 1'b1;
                end
                PH_DONE: begin
                    n_failed = 1'b1; // trailing byte
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase
        end
        if (w_end_sec) begin
            n_sec   = r_sec + 2'd1;
            n_pos   = 4'd0;
            n_acc   = 32'd0;
            n_phase = (n_sec == 2'(NUM_SECTIONS)) ? PH_DONE : PH_COUNT;
        end
    end

    assign o_complete = !n_failed && (n_phase == PH_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_last)) begin
            r_phase  <= PH_HEADER;
            r_pos    <= 4'd0;
            r_acc    <= 32'd0;
            r_skip   <= '0;
            r_sec    <= 2'd0;
            r_failed <= 1'b0;
        end else if (i_go) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_acc    <= n_acc;
            r_skip   <= n_skip;
            r_sec    <= n_sec;
            r_failed <= n_failed;
        end
    end

endmodule

/* sv/db_image_length_validator.sv */
// ----------------------------------------------------------------------------
// db_image_length_validator
// Streams a database image byte by byte and flags whether it is well formed.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained; a last byte waits in the input
//   register only while the result register is full and stalled.
// Result: the pass/fail result shows on o_out_valid from the result register
//   after the last byte leaves the input register, later while it is stalled.
// Reset: i_rst_n, synchronous, clears the parser, the valid bits of both
//   pipeline registers and all configuration registers; no clearing pass.
// ----------------------------------------------------------------------------
module db_image_length_validator
    import dbv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_image_byte,
    input  logic              i_is_last,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_image_complete,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg       w_cfg;

    // Input register: holds one accepted byte request
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Result register
    logic       r_out_vld;
    logic       r_out_ok;

    logic       w_go;
    logic       w_complete;
    logic       w_take;

    dbv_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Advance the held byte unless it is a last byte whose result would land on
    // a full result register that is still stalled. Non-last bytes never wait.
    assign w_take = r_out_vld && !i_out_stall;
    assign w_go   = r_in_vld && (!r_in_last || !r_out_vld || !i_out_stall);

    // Stall only while the held request cannot move on
    assign o_in_stall = r_in_vld && !w_go;

    dbv_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_go),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .i_cfg      (w_cfg),
        .o_complete (w_complete)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    // Payload capture needs no reset
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_image_byte;
            r_in_last <= i_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_go && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && r_in_last) begin
            r_out_ok <= w_complete;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_image_complete = r_out_ok;

    // A new result only appears after a last byte moved through the parser
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_go && r_in_last))
        else $error("result appeared without a last byte");

    // The input side only stalls for a last byte facing a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_last && o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // Reset empties the result register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule
